>>> rtl/ttsc_pkg.sv
package ttsc_pkg;

    localparam int ROW_BITS       = 10;
    localparam int POSE_FRAC_BITS = 16;
    localparam int GAIN_BITS      = 16;
    localparam int POSE_INT_BITS  = 8;
    localparam int POSE_W         = POSE_INT_BITS + POSE_FRAC_BITS;
    localparam int PROD_W         = ROW_BITS + GAIN_BITS;
    localparam int STEP_W         = ROW_BITS + POSE_FRAC_BITS;
    // pose plus two steps of either sign, with headroom and a sign bit
    localparam int SUM_W          = ROW_BITS + POSE_FRAC_BITS + 3;

    localparam int OP_W     = 2;
    localparam int TAG_W    = 8;
    localparam int CMD_W    = 8;
    localparam int WD_W     = 12;
    localparam int PHASE_W  = 6;
    localparam int LAC_W    = 12;
    localparam int SEEN_W   = 7;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    localparam logic [OP_W-1:0] OP_TICK         = 2'd0;
    localparam logic [OP_W-1:0] OP_DETECT       = 2'd1;
    localparam logic [OP_W-1:0] OP_SET_INTEREST = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_CENTRE_ROW    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DEADBAND_HIGH = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DEADBAND_LOW  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_STEP_GAIN     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_POSE_MIN      = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_POSE_MAX      = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_STALE_TICKS   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_LOST_TICKS    = 3'd7;

    localparam logic [ROW_BITS-1:0]      RST_CENTRE_ROW    = ROW_BITS'(240);
    localparam logic [ROW_BITS-1:0]      RST_DEADBAND_HIGH = ROW_BITS'(250);
    localparam logic [ROW_BITS-1:0]      RST_DEADBAND_LOW  = ROW_BITS'(230);
    localparam logic [GAIN_BITS-1:0]     RST_STEP_GAIN     = GAIN_BITS'(1507);
    localparam logic [POSE_INT_BITS-1:0] RST_POSE_MIN      = POSE_INT_BITS'(52);
    localparam logic [POSE_INT_BITS-1:0] RST_POSE_MAX      = POSE_INT_BITS'(148);
    localparam logic [WD_W-1:0]          RST_STALE_TICKS   = WD_W'(80);
    localparam logic [WD_W-1:0]          RST_LOST_TICKS    = WD_W'(2000);

    localparam logic [CMD_W-1:0]   CMD_MIN           = CMD_W'(43);
    localparam logic [CMD_W-1:0]   CMD_MAX           = CMD_W'(150);
    localparam logic [CMD_W-1:0]   LOW_CMD_LIMIT     = CMD_W'(77);
    localparam logic [PHASE_W-1:0] SWEEP_LAST_PHASE  = PHASE_W'(49);
    localparam logic [WD_W-1:0]    WD_MAX            = WD_W'(4095);
    localparam logic [WD_W-1:0]    FORCED_WATCHDOG   = WD_W'(3000);
    localparam logic [LAC_W-1:0]   LAC_MAX           = LAC_W'(4095);
    localparam logic [LAC_W-1:0]   LOW_COUNT_TRIGGER = LAC_W'(100);
    localparam logic [LAC_W-1:0]   LOW_COUNT_CAP     = LAC_W'(4000);
    localparam logic [SEEN_W-1:0]  SEEN_MAX          = SEEN_W'(100);
    localparam logic [SEEN_W-1:0]  SEEN_THRESHOLD    = SEEN_W'(3);
    localparam logic [TAG_W-1:0]   TAG_TARGET        = TAG_W'(25);
    localparam logic [TAG_W-1:0]   TAG_MARKER        = TAG_W'(35);

    localparam logic [POSE_W-1:0] POSE_ONE    = POSE_W'(1) << POSE_FRAC_BITS;
    localparam logic [POSE_W-1:0] POSE_RESET  = POSE_W'(100) << POSE_FRAC_BITS;
    localparam logic [POSE_W-1:0] SWEEP_START = POSE_W'(150) << POSE_FRAC_BITS;

    typedef struct packed {
        logic [ROW_BITS-1:0]      centre_row;
        logic [ROW_BITS-1:0]      deadband_high;
        logic [ROW_BITS-1:0]      deadband_low;
        logic [GAIN_BITS-1:0]     step_gain;
        logic [POSE_INT_BITS-1:0] pose_min;
        logic [POSE_INT_BITS-1:0] pose_max;
        logic [WD_W-1:0]          stale_ticks;
        logic [WD_W-1:0]          lost_ticks;
    } cfg_t;

    typedef struct packed {
        logic             servo_valid;
        logic [CMD_W-1:0] servo_cmd;
        logic             tag_lost;
        logic             marker_valid;
        logic             target_valid;
        logic [TAG_W-1:0] interest_id;
    } result_t;

    // product is Q.16 of the gain; bring it to the pose fraction
    function automatic logic [STEP_W-1:0] scale_step(input logic [PROD_W-1:0] prod);
        logic [PROD_W+POSE_FRAC_BITS-1:0] wide;
        wide = (PROD_W + POSE_FRAC_BITS)'(prod);
        if (POSE_FRAC_BITS >= GAIN_BITS)
        begin
            wide = wide << (POSE_FRAC_BITS - GAIN_BITS);
        end
        else
        begin
            wide = wide >> (GAIN_BITS - POSE_FRAC_BITS);
        end
        return wide[STEP_W-1:0];
    endfunction

endpackage

>>> rtl/ttsc_if.sv
interface ttsc_in_if;
    logic                               valid;
    logic                               ready;
    logic [ttsc_pkg::OP_W-1:0]          operation;
    logic [ttsc_pkg::TAG_W-1:0]         tag_id;
    logic [ttsc_pkg::ROW_BITS-1:0]      centre_y;

    modport source (output valid, operation, tag_id, centre_y, input ready);
    modport sink   (input valid, operation, tag_id, centre_y, output ready);
endinterface

interface ttsc_out_if;
    logic                               valid;
    logic                               ready;
    logic                               servo_valid;
    logic [ttsc_pkg::CMD_W-1:0]         servo_cmd;
    logic                               tag_lost;
    logic                               marker_valid;
    logic                               target_valid;
    logic [ttsc_pkg::TAG_W-1:0]         interest_id;

    modport source (output valid, servo_valid, servo_cmd, tag_lost, marker_valid,
                    target_valid, interest_id, input ready);
    modport sink   (input valid, servo_valid, servo_cmd, tag_lost, marker_valid,
                    target_valid, interest_id, output ready);
endinterface

>>> rtl/tag_tracking_servo_controller_core.sv
// pan servo controller that keeps a camera tag on a configured image row
// in_ch carries one operation per transfer: tick, tag detection or set tag
// of interest; out_ch returns exactly one result per input item, in order
// configuration is an apb-style port, register i at byte address 4*i,
// writes complete in the access cycle (pready tied high), reads return value
// an input transfer is registered at its edge, then the state update and
// result are computed and the result is written into the result queue
// throughput: one item per cycle while the queue has room; the limit is
// the loop through the pose, watchdog and counter registers, which every
// item reads and writes
// a two-entry result queue sits on the output, so one more item is taken
// while a result waits; when out_ch stalls with the queue full, in_ch.ready
// drops and the held item waits in the input register
// reset (rst_n low, asynchronous) loads the register defaults, pose 100.0,
// tag of interest 35, clears the watchdog, counters and flags, and empties
// the input register and the result queue; no clearing pass is needed
module tag_tracking_servo_controller_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ttsc_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [ttsc_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [ttsc_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    ttsc_in_if.sink                             in_ch,
    ttsc_out_if.source                          out_ch
);

    localparam int PW = ttsc_pkg::POSE_W;
    localparam int SW = ttsc_pkg::SUM_W;
    localparam int FB = ttsc_pkg::POSE_FRAC_BITS;

    // configuration registers
    ttsc_pkg::cfg_t                         cfg_reg;
    logic [ttsc_pkg::REG_IDX_W-1:0]         reg_idx;
    logic                                   cfg_write;

    // input register
    logic                                   s1_valid_reg;
    logic [ttsc_pkg::OP_W-1:0]              s1_op_reg;
    logic [ttsc_pkg::TAG_W-1:0]             s1_tag_reg;
    logic [ttsc_pkg::ROW_BITS-1:0]          s1_row_reg;
    logic                                   advance;

    // tracking state
    logic [PW-1:0]                          pose_reg, pose_next;
    logic [ttsc_pkg::WD_W-1:0]              wd_reg, wd_next;
    logic [ttsc_pkg::PHASE_W-1:0]           phase_reg, phase_next;
    logic [ttsc_pkg::LAC_W-1:0]             lac_reg, lac_next;
    logic [ttsc_pkg::SEEN_W-1:0]            seen_reg, seen_next;
    logic [ttsc_pkg::TAG_W-1:0]             interest_reg, interest_next;
    logic                                   lost_reg, lost_next;
    logic                                   marker_reg, marker_next;
    logic                                   target_reg, target_next;

    // result queue
    ttsc_pkg::result_t                      q_mem_reg [2];
    logic                                   q_wr_reg, q_rd_reg;
    logic [1:0]                             q_cnt_reg, q_cnt_next;
    logic                                   q_pop;
    ttsc_pkg::result_t                      res;
    ttsc_pkg::result_t                      q_head;

    // datapath
    logic [ttsc_pkg::WD_W-1:0]              wd_inc;
    logic [ttsc_pkg::PHASE_W-1:0]           phase_inc;
    logic                                   stale_now, lost_now;
    logic [PW-1:0]                          sweep_base, sweep_pose;
    logic [ttsc_pkg::ROW_BITS-1:0]          row_err;
    logic [ttsc_pkg::PROD_W-1:0]            prod;
    logic [ttsc_pkg::STEP_W-1:0]            step;
    logic signed [SW-1:0]                   det_sum;
    logic signed [SW-1:0]                   pmax_fix, pmin_fix;
    logic [PW-1:0]                          det_pose;
    logic [ttsc_pkg::SEEN_W-1:0]            seen_inc;
    logic [ttsc_pkg::TAG_W-1:0]             det_interest;
    logic                                   det_match;
    logic [PW-1:0]                          cmd_pose;
    logic [ttsc_pkg::TAG_W-1:0]             cmd_interest;
    logic [ttsc_pkg::CMD_W-1:0]             cmd_whole, cmd;
    logic [ttsc_pkg::LAC_W-1:0]             lac_inc, lac_final;
    logic                                   force_wd;
    logic                                   issue;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign reg_idx   = paddr[ttsc_pkg::CFG_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.centre_row    <= ttsc_pkg::RST_CENTRE_ROW;
            cfg_reg.deadband_high <= ttsc_pkg::RST_DEADBAND_HIGH;
            cfg_reg.deadband_low  <= ttsc_pkg::RST_DEADBAND_LOW;
            cfg_reg.step_gain     <= ttsc_pkg::RST_STEP_GAIN;
            cfg_reg.pose_min      <= ttsc_pkg::RST_POSE_MIN;
            cfg_reg.pose_max      <= ttsc_pkg::RST_POSE_MAX;
            cfg_reg.stale_ticks   <= ttsc_pkg::RST_STALE_TICKS;
            cfg_reg.lost_ticks    <= ttsc_pkg::RST_LOST_TICKS;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                ttsc_pkg::REG_CENTRE_ROW:
                    cfg_reg.centre_row <= pwdata[ttsc_pkg::ROW_BITS-1:0];
                ttsc_pkg::REG_DEADBAND_HIGH:
                    cfg_reg.deadband_high <= pwdata[ttsc_pkg::ROW_BITS-1:0];
                ttsc_pkg::REG_DEADBAND_LOW:
                    cfg_reg.deadband_low <= pwdata[ttsc_pkg::ROW_BITS-1:0];
                ttsc_pkg::REG_STEP_GAIN:
                    cfg_reg.step_gain <= pwdata[ttsc_pkg::GAIN_BITS-1:0];
                ttsc_pkg::REG_POSE_MIN:
                    cfg_reg.pose_min <= pwdata[ttsc_pkg::POSE_INT_BITS-1:0];
                ttsc_pkg::REG_POSE_MAX:
                    cfg_reg.pose_max <= pwdata[ttsc_pkg::POSE_INT_BITS-1:0];
                ttsc_pkg::REG_STALE_TICKS:
                    cfg_reg.stale_ticks <= pwdata[ttsc_pkg::WD_W-1:0];
                ttsc_pkg::REG_LOST_TICKS:
                    cfg_reg.lost_ticks <= pwdata[ttsc_pkg::WD_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            ttsc_pkg::REG_CENTRE_ROW:    prdata = 32'(cfg_reg.centre_row);
            ttsc_pkg::REG_DEADBAND_HIGH: prdata = 32'(cfg_reg.deadband_high);
            ttsc_pkg::REG_DEADBAND_LOW:  prdata = 32'(cfg_reg.deadband_low);
            ttsc_pkg::REG_STEP_GAIN:     prdata = 32'(cfg_reg.step_gain);
            ttsc_pkg::REG_POSE_MIN:      prdata = 32'(cfg_reg.pose_min);
            ttsc_pkg::REG_POSE_MAX:      prdata = 32'(cfg_reg.pose_max);
            ttsc_pkg::REG_STALE_TICKS:   prdata = 32'(cfg_reg.stale_ticks);
            ttsc_pkg::REG_LOST_TICKS:    prdata = 32'(cfg_reg.lost_ticks);
            default:                     prdata = '0;
        endcase
    end

    // ---------------- input register ----------------
    assign advance     = s1_valid_reg && (q_cnt_reg != 2'd2);
    assign in_ch.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            s1_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            s1_op_reg  <= in_ch.operation;
            s1_tag_reg <= in_ch.tag_id;
            s1_row_reg <= in_ch.centre_y;
        end
    end

    // ---------------- tick path ----------------
    assign wd_inc    = (wd_reg != ttsc_pkg::WD_MAX) ? wd_reg + 1'b1 : wd_reg;
    assign phase_inc = (phase_reg >= ttsc_pkg::SWEEP_LAST_PHASE) ? '0 : phase_reg + 1'b1;
    assign stale_now = wd_inc > cfg_reg.stale_ticks;
    assign lost_now  = wd_inc > cfg_reg.lost_ticks;
    // first tick past the lost limit restarts the sweep from the top
    assign sweep_base = lost_reg ? pose_reg : ttsc_pkg::SWEEP_START;
    assign sweep_pose = (sweep_base < ttsc_pkg::POSE_ONE) ? ttsc_pkg::SWEEP_START
                                                          : sweep_base - ttsc_pkg::POSE_ONE;

    // ---------------- detection path ----------------
    assign seen_inc = (seen_reg < ttsc_pkg::SEEN_MAX) ? seen_reg + 1'b1 : seen_reg;
    assign det_interest = (s1_tag_reg == ttsc_pkg::TAG_TARGET &&
                           seen_inc > ttsc_pkg::SEEN_THRESHOLD) ? ttsc_pkg::TAG_TARGET
                                                                : interest_reg;
    assign det_match = s1_tag_reg == det_interest;

    assign row_err = (s1_row_reg >= cfg_reg.centre_row) ? s1_row_reg - cfg_reg.centre_row
                                                        : cfg_reg.centre_row - s1_row_reg;
    assign prod = ttsc_pkg::PROD_W'(row_err) * ttsc_pkg::PROD_W'(cfg_reg.step_gain);
    assign step = ttsc_pkg::scale_step(prod);

    assign pmax_fix = $signed(SW'({cfg_reg.pose_max, {FB{1'b0}}}));
    assign pmin_fix = $signed(SW'({cfg_reg.pose_min, {FB{1'b0}}}));

    // both deadband tests apply in turn, then max clamp, then min clamp
    always_comb
    begin
        det_sum = $signed(SW'(pose_reg));
        if (s1_row_reg >= cfg_reg.deadband_high)
        begin
            det_sum = det_sum - $signed(SW'(step));
        end
        if (s1_row_reg < cfg_reg.deadband_low)
        begin
            det_sum = det_sum + $signed(SW'(step));
        end
        if (det_sum > pmax_fix)
        begin
            det_sum = pmax_fix;
        end
        if (det_sum < pmin_fix)
        begin
            det_sum = pmin_fix;
        end
        det_pose = det_sum[PW-1:0];
    end

    // ---------------- command issue ----------------
    assign cmd_pose     = (s1_op_reg == ttsc_pkg::OP_TICK) ? sweep_pose : det_pose;
    assign cmd_interest = (s1_op_reg == ttsc_pkg::OP_DETECT) ? det_interest : interest_reg;
    assign cmd_whole    = cmd_pose[PW-1:FB];

    always_comb
    begin
        if (cmd_whole > ttsc_pkg::CMD_MAX)
        begin
            cmd = ttsc_pkg::CMD_MAX;
        end
        else if (cmd_whole < ttsc_pkg::CMD_MIN)
        begin
            cmd = ttsc_pkg::CMD_MIN;
        end
        else
        begin
            cmd = cmd_whole;
        end
    end

    assign lac_inc = (cmd <= ttsc_pkg::LOW_CMD_LIMIT)
                   ? ((lac_reg != ttsc_pkg::LAC_MAX) ? lac_reg + 1'b1 : lac_reg)
                   : '0;
    // long stay at low angle while following the marker forces the lost path
    assign force_wd  = (lac_inc > ttsc_pkg::LOW_COUNT_TRIGGER) &&
                       (cmd_interest == ttsc_pkg::TAG_MARKER);
    assign lac_final = (force_wd && lac_inc > ttsc_pkg::LOW_COUNT_CAP)
                     ? ttsc_pkg::LOW_COUNT_CAP : lac_inc;

    // ---------------- state update ----------------
    always_comb
    begin
        pose_next     = pose_reg;
        wd_next       = wd_reg;
        phase_next    = phase_reg;
        lac_next      = lac_reg;
        seen_next     = seen_reg;
        interest_next = interest_reg;
        lost_next     = lost_reg;
        marker_next   = marker_reg;
        target_next   = target_reg;
        issue         = 1'b0;

        if (advance)
        begin
            case (s1_op_reg)
                ttsc_pkg::OP_TICK:
                begin
                    wd_next    = wd_inc;
                    phase_next = phase_inc;
                    if (stale_now || lost_now)
                    begin
                        marker_next = 1'b0;
                        target_next = 1'b0;
                    end
                    if (lost_now)
                    begin
                        lost_next = 1'b1;
                        pose_next = sweep_base;
                        if (phase_inc == '0)
                        begin
                            issue     = 1'b1;
                            pose_next = (sweep_pose == '0) ? ttsc_pkg::SWEEP_START
                                                           : sweep_pose;
                        end
                    end
                end
                ttsc_pkg::OP_DETECT:
                begin
                    if (s1_tag_reg == ttsc_pkg::TAG_TARGET)
                    begin
                        seen_next     = seen_inc;
                        interest_next = det_interest;
                        target_next   = 1'b1;
                    end
                    else if (s1_tag_reg == ttsc_pkg::TAG_MARKER)
                    begin
                        marker_next = 1'b1;
                    end
                    if (det_match)
                    begin
                        issue      = 1'b1;
                        wd_next    = '0;
                        phase_next = '0;
                        lost_next  = 1'b0;
                        pose_next  = det_pose;
                    end
                end
                ttsc_pkg::OP_SET_INTEREST:
                begin
                    interest_next = s1_tag_reg;
                end
                default:
                begin
                end
            endcase

            if (issue)
            begin
                lac_next = lac_final;
                if (force_wd)
                begin
                    wd_next    = ttsc_pkg::FORCED_WATCHDOG;
                    phase_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pose_reg     <= ttsc_pkg::POSE_RESET;
            wd_reg       <= '0;
            phase_reg    <= '0;
            lac_reg      <= '0;
            seen_reg     <= '0;
            interest_reg <= ttsc_pkg::TAG_MARKER;
            lost_reg     <= 1'b0;
            marker_reg   <= 1'b0;
            target_reg   <= 1'b0;
        end
        else
        begin
            pose_reg     <= pose_next;
            wd_reg       <= wd_next;
            phase_reg    <= phase_next;
            lac_reg      <= lac_next;
            seen_reg     <= seen_next;
            interest_reg <= interest_next;
            lost_reg     <= lost_next;
            marker_reg   <= marker_next;
            target_reg   <= target_next;
        end
    end

    always_comb
    begin
        res.servo_valid  = issue;
        res.servo_cmd    = issue ? cmd : '0;
        res.tag_lost     = lost_next;
        res.marker_valid = marker_next;
        res.target_valid = target_next;
        res.interest_id  = interest_next;
    end

    // ---------------- result queue ----------------
    assign q_pop      = out_ch.valid && out_ch.ready;
    assign q_cnt_next = q_cnt_reg + {1'b0, advance} - {1'b0, q_pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_reg  <= 1'b0;
            q_rd_reg  <= 1'b0;
            q_cnt_reg <= '0;
        end
        else
        begin
            q_cnt_reg <= q_cnt_next;
            if (advance)
            begin
                q_wr_reg <= ~q_wr_reg;
            end
            if (q_pop)
            begin
                q_rd_reg <= ~q_rd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            q_mem_reg[q_wr_reg] <= res;
        end
    end

    assign q_head              = q_mem_reg[q_rd_reg];
    assign out_ch.valid        = q_cnt_reg != 2'd0;
    assign out_ch.servo_valid  = q_head.servo_valid;
    assign out_ch.servo_cmd    = q_head.servo_cmd;
    assign out_ch.tag_lost     = q_head.tag_lost;
    assign out_ch.marker_valid = q_head.marker_valid;
    assign out_ch.target_valid = q_head.target_valid;
    assign out_ch.interest_id  = q_head.interest_id;

endmodule

>>> rtl/ttsc_checker.sv
module ttsc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic                             servo_valid,
    input logic [ttsc_pkg::CMD_W-1:0]       servo_cmd,
    input logic                             tag_lost,
    input logic                             marker_valid,
    input logic                             target_valid,
    input logic [ttsc_pkg::TAG_W-1:0]       interest_id
);

    // a stalled result keeps its place and its contents
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid &&
            $stable({servo_valid, servo_cmd, tag_lost, marker_valid, target_valid,
                     interest_id}))
        else $error("result changed while stalled");

    // an issued command is always inside the servo range
    a_cmd_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && servo_valid |->
            servo_cmd >= ttsc_pkg::CMD_MIN && servo_cmd <= ttsc_pkg::CMD_MAX)
        else $error("servo command outside range");

    // no command means a zero command field
    a_cmd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !servo_valid |-> servo_cmd == '0)
        else $error("command field set without a command");

    // nothing is offered in the first cycle out of reset
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !out_valid)
        else $error("result offered right after reset");

endmodule

bind tag_tracking_servo_controller_core ttsc_checker u_ttsc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .servo_valid  (out_ch.servo_valid),
    .servo_cmd    (out_ch.servo_cmd),
    .tag_lost     (out_ch.tag_lost),
    .marker_valid (out_ch.marker_valid),
    .target_valid (out_ch.target_valid),
    .interest_id  (out_ch.interest_id)
);
